[hw/rtl/htfd_pkg.sv]
// Shared constants and the CRC-8 byte step for the humidity/temperature frame decoder.
`timescale 1ns / 1ps

package htfd_pkg;

	localparam int BYTE_W      = 8;
	localparam int OFFSET_W    = 12;
	localparam int TEMP_OUT_W  = 15;
	localparam int HUM_OUT_W   = 14;
	localparam int WORD_W      = 16;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_ADDR_W  = 3;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	// Conversion constants, hundredths of a unit per full-scale word
	localparam int TEMP_SCALE = 17500;
	localparam int TEMP_BIAS  = 4500;
	localparam int HUM_SCALE  = 10000;

	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 12'sd400;

	// One byte through the 0x31 polynomial, MSB first
	function automatic logic [BYTE_W-1:0] crc8_byte(
		input logic [BYTE_W-1:0] crc_in,
		input logic [BYTE_W-1:0] data
	);
		logic [BYTE_W-1:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[hw/rtl/humidity_temperature_frame_decoder.sv]
// Top level of the six-byte temperature/humidity measurement frame decoder.
`timescale 1ns / 1ps

// Usage
//  Input stream: one frame byte per transfer in s_axis_tdata[7:0]; s_axis_tuser
//  high marks byte 0 of a frame and realigns the byte count (partial frame dropped).
//  Frame order: temperature MSB, LSB, CRC, humidity MSB, LSB, CRC.
//  Output stream: one transfer per completed frame, carrying the converted
//  temperature and humidity in hundredths and a CRC-ok flag per word. Values are
//  delivered even when a CRC does not match; only the flag drops.
//  Config: APB register 0 at address 0, temp_offset_centi (12 bit signed),
//  subtracted from the temperature. Write only while the stream is idle.
//  Result path: the sixth byte passes the input register, then the output register,
//  which drives m_axis_tvalid; a held earlier result can stall it in between.
//  Throughput: one byte per cycle if not stalled; the CRC byte step and both
//  scaling multiplies sit in the single stage between input and output registers.
//  Stall: a held result blocks only a byte that would finish another frame;
//  other bytes keep flowing. s_axis_tready falls while the input register
//  holds such a byte and the output register is still full and not taken.
//  Reset: byte count 0, CRC 0xFF, offset 400, both registers empty.

module humidity_temperature_frame_decoder
	import htfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
	input  logic                  s_axis_tuser,  // [0] frame_start
	// Output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [14:0] temperature_centi, [28:15] humidity_centi, [29] temp_crc_ok,
	// [30] humidity_crc_ok, [31] zero
	output logic [31:0]           m_axis_tdata,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	typedef enum logic [2:0] {
		POS_T_HI  = 3'd0,
		POS_T_LO  = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_HI  = 3'd3,
		POS_H_LO  = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	// Config register
	logic signed [OFFSET_W-1:0] offset_q;
	logic                       reg0_sel;

	assign pready   = 1'b1;
	assign reg0_sel = (paddr[CFG_ADDR_W-1] == 1'b0);
	assign prdata   = reg0_sel ? CFG_DATA_W'(offset_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (psel && penable && pwrite && pready && reg0_sel) begin
			offset_q <= pwdata[OFFSET_W-1:0];
		end
	end

	// Input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;
	logic              adv;
	logic              s_take;

	// Frame state
	pos_t              pos_q;
	logic [BYTE_W-1:0] crc_q;
	logic [WORD_W-1:0] tword_q;
	logic              tok_q;
	logic [BYTE_W-1:0] hhi_q;
	logic [BYTE_W-1:0] hlo_q;

	// Output register
	logic        m_valid_q;
	logic [31:0] m_data_q;

	pos_t eff_pos;
	logic is_last;
	logic load_out;

	assign eff_pos  = (start_s1 || (pos_q > POS_H_CRC)) ? POS_T_HI : pos_q;
	assign is_last  = (eff_pos == POS_H_CRC);
	// A frame-ending byte waits while the previous result has not been taken
	assign adv      = valid_s1 && (!is_last || !m_valid_q || m_axis_tready);
	assign load_out = adv && is_last;

	assign s_axis_tready = !valid_s1 || adv;
	assign s_take        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// Conversion of the completed frame
	logic [30:0]                   temp_prod;
	logic [29:0]                   hum_prod;
	logic [TEMP_OUT_W-1:0]         temp_conv;
	logic [HUM_OUT_W-1:0]          hum_conv;
	logic signed [WORD_W-1:0]      temp_calc;
	logic                          hum_ok;

	assign temp_prod = 31'(tword_q) * 31'(TEMP_SCALE);
	assign hum_prod  = 30'({hhi_q, hlo_q}) * 30'(HUM_SCALE);
	assign temp_conv = temp_prod[30:16];
	assign hum_conv  = hum_prod[29:16];
	// Range stays within 15 bits signed for any offset
	assign temp_calc = $signed({1'b0, temp_conv}) - 16'(TEMP_BIAS)
	                   - {{(WORD_W-OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};
	assign hum_ok    = (crc_q == byte_s1);

	// Next-state logic
	pos_t              pos_d;
	logic [BYTE_W-1:0] crc_d;
	logic [WORD_W-1:0] tword_d;
	logic              tok_d;
	logic [BYTE_W-1:0] hhi_d;
	logic [BYTE_W-1:0] hlo_d;

	always_comb begin
		pos_d   = pos_q;
		crc_d   = crc_q;
		tword_d = tword_q;
		tok_d   = tok_q;
		hhi_d   = hhi_q;
		hlo_d   = hlo_q;
		case (eff_pos)
			POS_T_HI: begin
				crc_d   = crc8_byte(CRC_INIT, byte_s1);
				tword_d = {byte_s1, 8'h00};
				pos_d   = POS_T_LO;
			end
			POS_T_LO: begin
				crc_d   = crc8_byte(crc_q, byte_s1);
				tword_d = {tword_q[WORD_W-1:BYTE_W], byte_s1};
				pos_d   = POS_T_CRC;
			end
			POS_T_CRC: begin
				tok_d = (crc_q == byte_s1);
				crc_d = CRC_INIT;
				pos_d = POS_H_HI;
			end
			POS_H_HI: begin
				crc_d = crc8_byte(CRC_INIT, byte_s1);
				hhi_d = byte_s1;
				pos_d = POS_H_LO;
			end
			POS_H_LO: begin
				crc_d = crc8_byte(crc_q, byte_s1);
				hlo_d = byte_s1;
				pos_d = POS_H_CRC;
			end
			POS_H_CRC: begin
				crc_d = CRC_INIT;
				pos_d = POS_T_HI;
			end
			default: begin
				crc_d = CRC_INIT;
				pos_d = POS_T_HI;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_T_HI;
			crc_q   <= CRC_INIT;
			tword_q <= '0;
			tok_q   <= 1'b0;
			hhi_q   <= '0;
			hlo_q   <= '0;
		end else if (adv) begin
			pos_q   <= pos_d;
			crc_q   <= crc_d;
			tword_q <= tword_d;
			tok_q   <= tok_d;
			hhi_q   <= hhi_d;
			hlo_q   <= hlo_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {1'b0, hum_ok, tok_q, hum_conv, temp_calc[TEMP_OUT_W-1:0]};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_H_CRC)
		else $error("byte position out of range");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (m_axis_tvalid && (crc_q == CRC_INIT) && (pos_q == POS_T_HI)))
		else $error("frame end did not present result and restart CRC");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && is_last && m_valid_q && !m_axis_tready))
		else $error("input stalled without a blocked result");

	a_tcrc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (eff_pos == POS_T_CRC)) |=> (crc_q == CRC_INIT))
		else $error("CRC not restarted after temperature check byte");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the temperature/humidity measurement frame decoder.
`timescale 1ns / 1ps

module testbench;
	import htfd_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
	localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up
	localparam int PHASES       = 8;
	localparam int PHASE_BYTES  = 138;
	localparam int IDLE_PCT     = 76;
	localparam int BOTH_PCT     = 19;

	// Register map: temp_offset_centi is register 0, byte address 0
	localparam logic [CFG_ADDR_W-1:0] ADDR_TEMP_OFFSET = '0;

	localparam logic [7:0] SEED          = 8'hFF;
	localparam logic [7:0] POLY          = 8'h31;
	localparam int         T_SPAN        = 17500;
	localparam int         T_BIAS        = 4500;
	localparam int         H_SPAN        = 10000;
	localparam int         OFFSET_AT_RST = 400;

	typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;

	// Same bit order as m_axis_tdata[30:0]: temperature at the bottom
	typedef struct packed {
		logic               hum_ok;
		logic               temp_ok;
		logic [13:0]        hum;
		logic signed [14:0] temp;
	} meas_t;

	typedef struct {
		logic [7:0] b;
		logic       start;
		bit         typed;   // want holds a hand-worked result
		meas_t      want;
	} stim_row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;   // [7:0] data_byte
	logic                  s_axis_tuser  = 1'b0; // [0] frame_start
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [14:0] temperature_centi, [28:15] humidity_centi, [29] temp_crc_ok,
	// [30] humidity_crc_ok
	logic [31:0]           m_axis_tdata;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr         = '0;
	logic [CFG_DATA_W-1:0] pwdata        = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	flow_t     flow         = FLOW_FREE;
	int        fails        = 0;
	int        bytes_sent   = 0;
	int        quiet_cycles = 0;
	meas_t     pending_meas[$];
	stim_row_t directed_rows[$];

	// Decoder state as the frame is walked byte by byte
	logic signed [11:0] offset_q = OFFSET_AT_RST;
	logic [2:0]         pos_q    = '0;
	logic [7:0]         crc_q    = SEED;
	logic [15:0]        tword_q  = '0;
	logic               tok_q    = 1'b0;
	logic [7:0]         hhi_q    = '0;
	logic [7:0]         hlo_q    = '0;

	humidity_temperature_frame_decoder u_top (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [7:0] sensor_crc(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ POLY) : {c[6:0], 1'b0};
		return c;
	endfunction

	// Advances the frame state by one byte; returns 1 when the frame completes
	function automatic bit decode_byte(input logic [7:0] b, input logic start,
			output meas_t r);
		int          t_val;
		int          h_val;
		logic [15:0] h_word;
		r = '0;
		if (start || pos_q > 3'd5) begin
			pos_q = '0;
			crc_q = SEED;
		end
		case (pos_q)
			3'd0: begin
				crc_q   = sensor_crc(SEED, b);
				tword_q = {b, 8'h00};
			end
			3'd1: begin
				crc_q        = sensor_crc(crc_q, b);
				tword_q[7:0] = b;
			end
			3'd2: begin
				tok_q = (crc_q == b);
				crc_q = SEED;
			end
			3'd3: begin
				crc_q = sensor_crc(SEED, b);
				hhi_q = b;
			end
			3'd4: begin
				crc_q = sensor_crc(crc_q, b);
				hlo_q = b;
			end
			default: begin
				h_word    = {hhi_q, hlo_q};
				// products stay below 2^31, so plain int division is a floor
				t_val     = (T_SPAN * int'(tword_q)) / 65536 - T_BIAS - int'(offset_q);
				h_val     = (H_SPAN * int'(h_word)) / 65536;
				r.temp    = t_val[14:0];
				r.hum     = h_val[13:0];
				r.temp_ok = tok_q;
				r.hum_ok  = (crc_q == b);
				crc_q     = SEED;
				pos_q     = '0;
				return 1'b1;
			end
		endcase
		pos_q = pos_q + 3'd1;
		return 1'b0;
	endfunction

	function automatic bit stall_draw(input bit sink);
		int pct;
		case (flow)
			FLOW_FREE:       pct = 0;
			FLOW_SRC_IDLE:   pct = sink ? 0 : IDLE_PCT;
			FLOW_SINK_STALL: pct = sink ? IDLE_PCT : 0;
			default:         pct = BOTH_PCT;
		endcase
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic add_row(input logic [7:0] b, input logic start, input bit typed,
			input int t, input int h, input bit tok, input bit hok);
		stim_row_t row;
		row.b            = b;
		row.start        = start;
		row.typed        = typed;
		row.want.temp    = t[14:0];
		row.want.hum     = h[13:0];
		row.want.temp_ok = tok;
		row.want.hum_ok  = hok;
		directed_rows.push_back(row);
	endtask

	// One input transfer; the prediction is taken at the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic start,
			output bit produced, output meas_t r);
		while (stall_draw(1'b0)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= start;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		produced = decode_byte(b, start, r);
		bytes_sent++;
	endtask

	task automatic put_byte(input logic [7:0] b, input logic start);
		bit    produced;
		meas_t r;
		send_byte(b, start, produced, r);
		if (produced) pending_meas.push_back(r);
	endtask

	// Mostly whole frames with correct CRCs; some bad CRCs, some cut short
	task automatic send_frame();
		logic [15:0] tw;
		logic [15:0] hw;
		logic [7:0]  fb[6];
		logic        st;
		int          len;
		tw    = pick_word();
		hw    = pick_word();
		fb[0] = tw[15:8];
		fb[1] = tw[7:0];
		fb[2] = sensor_crc(sensor_crc(SEED, tw[15:8]), tw[7:0]);
		fb[3] = hw[15:8];
		fb[4] = hw[7:0];
		fb[5] = sensor_crc(sensor_crc(SEED, hw[15:8]), hw[7:0]);
		if ($urandom_range(99) < 12) fb[2] ^= 8'($urandom_range(255, 1));
		if ($urandom_range(99) < 12) fb[5] ^= 8'($urandom_range(255, 1));
		// an aligned decoder takes a frame with or without the start flag
		st  = (pos_q == 3'd0) ? 1'($urandom_range(1)) : 1'b1;
		len = ($urandom_range(99) < 10) ? $urandom_range(5, 1) : 6;
		for (int i = 0; i < len; i++) put_byte(fb[i], (i == 0) ? st : 1'b0);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(5, 1);
		repeat (n) put_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_meas.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup phase, access phase, then the bus returns to idle
	task automatic apb_access(input logic write, input logic [CFG_ADDR_W-1:0] addr,
			input logic [CFG_DATA_W-1:0] wdata, output logic [CFG_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic verify_offset();
		logic [CFG_DATA_W-1:0] rd;
		apb_access(1'b0, ADDR_TEMP_OFFSET, '0, rd);
		if (rd[11:0] !== offset_q) begin
			$error("temp_offset_centi: expected %0d, got %0d", offset_q, $signed(rd[11:0]));
			fails++;
		end
	endtask

	task automatic set_offset(input int v);
		logic [CFG_DATA_W-1:0] rd;
		apb_access(1'b1, ADDR_TEMP_OFFSET, CFG_DATA_W'(v), rd);
		offset_q = v[11:0];
		verify_offset();
	endtask

	task automatic check_meas(input logic [31:0] d);
		meas_t got;
		meas_t want;
		got = d[30:0];
		if (pending_meas.size() == 0) begin
			$error("result transfer with no measurement pending: tdata %h", d);
			fails++;
		end else begin
			want = pending_meas.pop_front();
			if (got.temp !== want.temp) begin
				$error("temperature_centi: expected %0d, got %0d", want.temp, got.temp);
				fails++;
			end
			if (got.hum !== want.hum) begin
				$error("humidity_centi: expected %0d, got %0d", want.hum, got.hum);
				fails++;
			end
			if (got.temp_ok !== want.temp_ok) begin
				$error("temp_crc_ok: expected %0b, got %0b", want.temp_ok, got.temp_ok);
				fails++;
			end
			if (got.hum_ok !== want.hum_ok) begin
				$error("humidity_crc_ok: expected %0b, got %0b", want.hum_ok, got.hum_ok);
				fails++;
			end
		end
	endtask

	// Result side: check at the accepting edge, then draw the next tready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) check_meas(m_axis_tdata);
		m_axis_tready <= arst_n && !stall_draw(1'b1);
	end

	// Watchdog: any transfer on either stream or the config port counts as progress
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		bit    produced;
		meas_t r;
		int    val;
		int    first;
		bit    paused;

		// All-zero words at the reset offset of 400: CRC of 0x0000 is 0x81.
		// First byte without the start flag, since the count is already at zero.
		add_row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h81, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h81, 1'b0, 1'b1, -4900, 0, 1'b1, 1'b1);
		// Full-scale words: CRC of 0xFFFF is 0xAC
		add_row(8'hFF, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'hAC, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'hAC, 1'b0, 1'b1, 12599, 9999, 1'b1, 1'b1);
		// Both CRC bytes wrong: values still reported, flags low
		add_row(8'h00, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'hFF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b1, -4900, 9999, 1'b0, 1'b0);
		// Partial frame dropped by a start flag mid-frame
		add_row(8'h12, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h34, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'hBE, 1'b1, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'hEF, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h92, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h00, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);
		add_row(8'h81, 1'b0, 1'b0, 0, 0, 1'b0, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_offset();

		flow = FLOW_FREE;
		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].b, directed_rows[i].start, produced, r);
			if (produced)
				pending_meas.push_back(directed_rows[i].typed ? directed_rows[i].want : r);
		end

		// Random phases, each with its own offset and flow pattern
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0:       val = 0;
				1:       val = -2048;
				2:       val = 2047;
				3:       val = -2000;
				4:       val = 2000;
				7:       val = OFFSET_AT_RST;
				default: val = $signed(12'($urandom_range(4095)));
			endcase
			set_offset(val);
			flow   = flow_t'(ph % 4);
			first  = bytes_sent;
			paused = 1'b0;
			while (bytes_sent - first < PHASE_BYTES) begin
				// once, hold the input until every result is out
				if (ph == 2 && !paused && bytes_sent - first >= PHASE_BYTES / 2) begin
					s_axis_tvalid <= 1'b0;
					while (pending_meas.size() != 0) @(posedge clk);
					@(posedge clk);
					paused = 1'b1;
				end
				if ($urandom_range(99) < 80) send_frame();
				else send_noise();
			end
		end

		settle();
		if (fails == 0 && pending_meas.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
